// ===== sv/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ZVR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ZVR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/zvr_pkg.sv =====
`default_nettype none

package zvr_pkg;

	localparam int DATA_W = 32;
	localparam int ANG_W  = 26;
	localparam int COEF_W = 32;
	localparam int CW     = 34;
	localparam int PROD_W = 64;
	localparam int SUM_W  = 65;
	localparam int NUM_W  = 41;

	// Division by 360 as a division by 45 in two 19-bit digits.
	localparam int DIGIT_W   = 19;
	localparam int RMD_W     = 6;
	localparam int TRIAL_W   = 25;
	localparam int RECIP_W   = 26;
	localparam int RECIP_SH  = 31;
	localparam int QPROD_W   = 51;
	localparam int DIV_STEPS = 2;

	localparam logic signed [ANG_W-1:0] ANGLE_RESET = 26'sd5898240;
	localparam logic [RMD_W-1:0] DIV_BY = 6'd45;
	localparam logic [RECIP_W-1:0] RECIP_45 = 26'd47721859;
	localparam logic [COEF_W-1:0] KINV_Q30 = 32'h26DD3B6A;
	localparam logic [SUM_W-1:0] ROUND_HALF = 65'h2000_0000;
	localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic signed [DATA_W-1:0] vec_x;
		logic signed [DATA_W-1:0] vec_y;
		logic signed [DATA_W-1:0] vec_z;
	} vec_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] rot_x;
		logic signed [DATA_W-1:0] rot_y;
		logic signed [DATA_W-1:0] rot_z;
		logic                     saturated;
	} rot_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] cs;
		logic signed [COEF_W-1:0] sn;
	} coeff_t;

	// atan(2^-i) as a binary angle, 2^32 units per turn.
	function automatic logic [31:0] atan_bam(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000029;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			5'd30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== sv/zvr_coeff_gen.sv =====
`default_nettype none

module zvr_coeff_gen #(
	parameter int CORDIC_STAGES = 24,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [zvr_pkg::ANG_W-1:0]   cfg_wdata,
	output zvr_pkg::coeff_t                  coeff,
	output logic                             coeff_ok
);
	import zvr_pkg::*;

	localparam int REM_W = FRACTION_BITS + 27;
	localparam int SHIFT = 32 - FRACTION_BITS;
	localparam logic signed [REM_W-1:0] TURN = REM_W'(360) << FRACTION_BITS;
	localparam logic [1:0] QUAD_90  = 2'd1;
	localparam logic [1:0] QUAD_180 = 2'd2;
	localparam logic [1:0] QUAD_270 = 2'd3;

	typedef enum logic [2:0] {
		S_REDUCE,
		S_DIV,
		S_FOLD,
		S_CORDIC,
		S_APPLY,
		S_READY
	} state_t;

	state_t                   state_q;
	logic signed [REM_W-1:0]  rem_q;
	logic [NUM_W-1:0]         num_q;
	logic [RMD_W-1:0]         part_q;
	logic [31:0]              quot_q;
	logic [5:0]               cnt_q;
	logic [1:0]               quad_q;
	logic signed [CW-1:0]     x_q;
	logic signed [CW-1:0]     y_q;
	logic signed [CW-1:0]     z_q;
	coeff_t                   coeff_q;

	logic [TRIAL_W-1:0]       trial;
	logic [QPROD_W-1:0]       qprod;
	logic [DIGIT_W-1:0]       qdig;
	logic [RMD_W-1:0]         rmd;
	logic [31:0]              bam_rnd;
	logic [1:0]               quad;
	logic [31:0]              resid;
	logic [4:0]               idx;
	logic signed [CW-1:0]     dx;
	logic signed [CW-1:0]     dy;
	logic signed [CW-1:0]     atan_i;

	always_comb begin
		// 360 is 8 times 45: the low three numerator bits drop out and the
		// rest is divided by 45 one digit at a time with a reciprocal multiply.
		trial   = {part_q, num_q[NUM_W-1 -: DIGIT_W]};
		qprod   = QPROD_W'(trial) * QPROD_W'(RECIP_45);
		qdig    = qprod[RECIP_SH +: DIGIT_W];
		rmd     = RMD_W'(trial - TRIAL_W'(qdig) * TRIAL_W'(DIV_BY));
		bam_rnd = quot_q + 32'h2000_0000;
		quad    = bam_rnd[31:30];
		resid   = quot_q - {quad, 30'd0};
		idx     = cnt_q[4:0];
		dx      = y_q >>> idx;
		dy      = x_q >>> idx;
		atan_i  = signed'({2'b00, atan_bam(idx)});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_REDUCE;
			rem_q   <= REM_W'(ANGLE_RESET);
			num_q   <= '0;
			part_q  <= '0;
			quot_q  <= '0;
			cnt_q   <= '0;
			quad_q  <= '0;
			x_q     <= '0;
			y_q     <= '0;
			z_q     <= '0;
			coeff_q <= '0;
		end else if (cfg_we) begin
			state_q <= S_REDUCE;
			rem_q   <= REM_W'(signed'(cfg_wdata));
		end else begin
			case (state_q)
				S_REDUCE: begin
					// Bring the angle into [0, 360) degrees one turn at a time.
					if (rem_q < 0) begin
						rem_q <= rem_q + TURN;
					end else if (rem_q >= TURN) begin
						rem_q <= rem_q - TURN;
					end else begin
						num_q   <= (NUM_W'(rem_q) << SHIFT) + NUM_W'(180);
						part_q  <= '0;
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					// The quotient keeps only its low 32 bits, so the binary angle wraps.
					part_q <= rmd;
					quot_q <= {quot_q[31-DIGIT_W:0], qdig};
					num_q  <= num_q << DIGIT_W;
					cnt_q  <= cnt_q + 6'd1;
					if (cnt_q == 6'(DIV_STEPS - 1)) begin
						state_q <= S_FOLD;
					end
				end
				S_FOLD: begin
					quad_q  <= quad;
					x_q     <= CW'(signed'({1'b0, KINV_Q30}));
					y_q     <= '0;
					z_q     <= CW'(signed'(resid));
					cnt_q   <= '0;
					state_q <= S_CORDIC;
				end
				S_CORDIC: begin
					if (z_q >= 0) begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - atan_i;
					end else begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + atan_i;
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(CORDIC_STAGES - 1)) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					case (quad_q)
						QUAD_90: begin
							coeff_q.cs <= COEF_W'(-y_q);
							coeff_q.sn <= COEF_W'(x_q);
						end
						QUAD_180: begin
							coeff_q.cs <= COEF_W'(-x_q);
							coeff_q.sn <= COEF_W'(-y_q);
						end
						QUAD_270: begin
							coeff_q.cs <= COEF_W'(y_q);
							coeff_q.sn <= COEF_W'(-x_q);
						end
						default: begin
							coeff_q.cs <= COEF_W'(x_q);
							coeff_q.sn <= COEF_W'(y_q);
						end
					endcase
					state_q <= S_READY;
				end
				S_READY: begin
					state_q <= S_READY;
				end
				default: begin
					state_q <= S_REDUCE;
				end
			endcase
		end
	end

	assign coeff    = coeff_q;
	assign coeff_ok = (state_q == S_READY);

endmodule

`default_nettype wire

// ===== sv/zvr_rot_pipe.sv =====
`default_nettype none

module zvr_rot_pipe (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire zvr_pkg::coeff_t   coeff,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire zvr_pkg::vec_t     in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output zvr_pkg::rot_t          out_data
);
	import zvr_pkg::*;

	logic                      v_s1, v_s2, v_s3;
	logic                      adv1, adv2, adv3;

	logic signed [PROD_W-1:0]  xc_s1, ys_s1, xs_s1, yc_s1;
	logic signed [DATA_W-1:0]  z_s1;
	logic signed [SUM_W-1:0]   sx_s2, sy_s2;
	logic signed [DATA_W-1:0]  z_s2;
	rot_t                      rot_s3;

	logic signed [SUM_W-1:0]   shx, shy;
	logic                      sat_x, sat_y;

	// Each stage moves when its successor is empty or draining this cycle.
	assign adv3     = !v_s3 || out_ready;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	always_comb begin
		shx   = sx_s2 >>> 30;
		shy   = sy_s2 >>> 30;
		sat_x = !((&shx[SUM_W-1:DATA_W-1]) || !(|shx[SUM_W-1:DATA_W-1]));
		sat_y = !((&shy[SUM_W-1:DATA_W-1]) || !(|shy[SUM_W-1:DATA_W-1]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= in_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			xc_s1 <= in_data.vec_x * coeff.cs;
			ys_s1 <= in_data.vec_y * coeff.sn;
			xs_s1 <= in_data.vec_x * coeff.sn;
			yc_s1 <= in_data.vec_y * coeff.cs;
			z_s1  <= in_data.vec_z;
		end
		if (adv2) begin
			sx_s2 <= SUM_W'(xc_s1) - SUM_W'(ys_s1) + signed'(ROUND_HALF);
			sy_s2 <= SUM_W'(xs_s1) + SUM_W'(yc_s1) + signed'(ROUND_HALF);
			z_s2  <= z_s1;
		end
		if (adv3) begin
			if (sat_x) begin
				rot_s3.rot_x <= shx[SUM_W-1] ? SAT_MIN : SAT_MAX;
			end else begin
				rot_s3.rot_x <= shx[DATA_W-1:0];
			end
			if (sat_y) begin
				rot_s3.rot_y <= shy[SUM_W-1] ? SAT_MIN : SAT_MAX;
			end else begin
				rot_s3.rot_y <= shy[DATA_W-1:0];
			end
			rot_s3.rot_z     <= z_s2;
			rot_s3.saturated <= sat_x || sat_y;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = rot_s3;

endmodule

`default_nettype wire

// ===== sv/z_axis_vector_rotation.sv =====
// Channel   Beat                        Handshake
// in        vec_x, vec_y, vec_z         in_valid / in_ready
// out       rot_x, rot_y, rot_z, sat    out_valid / out_ready
// cfg       rotation angle (26 bits)    cfg_we, no wait
//
// One vector per cycle sustained while out_ready is high and no angle setup runs;
// results pass through the multiply, sum and round/saturate stages. After reset
// and each angle write, a sequencer derives cos and sin with in_ready low: it
// removes whole turns one at a time, divides by 360 in 19-bit digits, folds the
// angle to one quadrant, runs CORDIC_STAGES iterations and applies the quadrant.
// A stall on out_ready holds a stage only while it and every later stage are full.
`default_nettype none
`include "assert_macros.svh"

module z_axis_vector_rotation #(
	parameter int CORDIC_STAGES = 24,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire zvr_pkg::vec_t              in_data,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output zvr_pkg::rot_t                   out_data,
	input  wire logic                       cfg_we,
	input  wire logic [zvr_pkg::ANG_W-1:0]  cfg_wdata
);
	import zvr_pkg::*;

	coeff_t coeff;
	logic   coeff_ok;
	logic   pipe_ready;

	zvr_coeff_gen #(
		.CORDIC_STAGES (CORDIC_STAGES),
		.FRACTION_BITS (FRACTION_BITS)
	) u_coeff (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.coeff     (coeff),
		.coeff_ok  (coeff_ok)
	);

	zvr_rot_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.coeff     (coeff),
		.in_valid  (in_valid && coeff_ok),
		.in_ready  (pipe_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign in_ready = pipe_ready && coeff_ok;

	// A new angle must hold off input beats while cos and sin are rebuilt.
	`ZVR_ASSERT_NXT(a_cfg_holds_input, clk, arst_n, cfg_we, !in_ready, "input open after angle write")

	// The saturation flag only comes with a component pinned at a limit.
	`ZVR_ASSERT_IMP(a_sat_at_limit, clk, arst_n, out_valid && out_data.saturated, (out_data.rot_x == SAT_MAX) || (out_data.rot_x == SAT_MIN) || (out_data.rot_y == SAT_MAX) || (out_data.rot_y == SAT_MIN), "flag without clipped value")

endmodule

`default_nettype wire

// ===== bench/z_axis_vector_rotation_test.sv =====
module z_axis_vector_rotation_test;
	import zvr_pkg::*;

	localparam int STAGES = 24;
	localparam int FRAC = 16;
	localparam int PIPE_DEPTH = 4;
	localparam int PHASES = 14;
	localparam int BEATS_PER_PHASE = 109;
	localparam longint HALF_LSB = 64'sd536870912;

	localparam logic signed [DATA_W-1:0] VMAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] VMIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] ONE = 32'sd65536;

	localparam logic signed [ANG_W-1:0] A0 = 26'sd0;
	localparam logic signed [ANG_W-1:0] A45 = 26'sd2949120;
	localparam logic signed [ANG_W-1:0] A90 = 26'sd5898240;
	localparam logic signed [ANG_W-1:0] A135 = 26'sd8847360;
	localparam logic signed [ANG_W-1:0] A180 = 26'sd11796480;
	localparam logic signed [ANG_W-1:0] A270 = 26'sd17694720;
	localparam logic signed [ANG_W-1:0] A360 = 26'sd23592960;
	localparam logic signed [ANG_W-1:0] ANG_TOP = 26'sh1FF_FFFF;
	localparam logic signed [ANG_W-1:0] ANG_BOTTOM = 26'sh200_0000;

	typedef struct {
		logic signed [ANG_W-1:0] angle;
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic signed [DATA_W-1:0] z;
		bit known;
		rot_t want;
	} probe_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	vec_t in_data;
	logic out_valid;
	logic out_ready;
	rot_t out_data;
	logic cfg_we;
	logic [ANG_W-1:0] cfg_wdata;

	// Angle increments atan(2^-i) in binary angle units, 2^32 per turn.
	longint arctan_step [0:31] = '{
		64'sh20000000, 64'sh12E4051E, 64'sh09FB385B, 64'sh051111D4,
		64'sh028B0D43, 64'sh0145D7E1, 64'sh00A2F61E, 64'sh00517C55,
		64'sh0028BE53, 64'sh00145F2F, 64'sh000A2F98, 64'sh000517CC,
		64'sh00028BE6, 64'sh000145F3, 64'sh0000A2FA, 64'sh0000517D,
		64'sh000028BE, 64'sh0000145F, 64'sh00000A30, 64'sh00000518,
		64'sh0000028C, 64'sh00000146, 64'sh000000A3, 64'sh00000051,
		64'sh00000029, 64'sh00000014, 64'sh0000000A, 64'sh00000005,
		64'sh00000003, 64'sh00000001, 64'sh00000001, 64'sh00000000
	};

	probe_t probes [0:24] = '{
		'{A90, 32'sd0, 32'sd0, 32'sd0, 1'b1, {32'sd0, 32'sd0, 32'sd0, 1'b0}},
		'{A90, 32'sd0, 32'sd0, VMAX, 1'b1, {32'sd0, 32'sd0, VMAX, 1'b0}},
		'{A90, 32'sd0, 32'sd0, VMIN, 1'b1, {32'sd0, 32'sd0, VMIN, 1'b0}},
		'{A90, ONE, 32'sd0, 32'sd5, 1'b0, '0},
		'{A90, VMAX, VMAX, -32'sd1, 1'b0, '0},
		'{A90, VMIN, VMIN, 32'sd1, 1'b0, '0},
		'{A0, VMIN, VMAX, 32'sh5555_5555, 1'b0, '0},
		'{A0, 32'sd98304, -32'sd147456, -32'sd1, 1'b0, '0},
		'{A0, 32'sd0, 32'sd0, 32'shAAAA_AAAA, 1'b1,
			{32'sd0, 32'sd0, 32'shAAAA_AAAA, 1'b0}},
		'{A45, VMAX, VMAX, 32'sd0, 1'b0, '0},
		'{A45, VMIN, VMIN, 32'sd0, 1'b0, '0},
		'{A45, VMAX, VMIN, VMIN, 1'b0, '0},
		'{A135, ONE, ONE, ONE, 1'b0, '0},
		'{A180, VMIN, 32'sd0, 32'sd0, 1'b0, '0},
		'{A180, ONE, 32'sd131072, 32'sh7FFF_0000, 1'b0, '0},
		'{A270, ONE, 32'sd0, 32'sd1, 1'b0, '0},
		'{A360, VMIN, VMIN, VMAX, 1'b0, '0},
		'{-A360, 32'sd12345678, -32'sd87654321, 32'sd0, 1'b0, '0},
		'{-A90, 32'sh1234_5678, 32'shEDCB_A988, 32'sd0, 1'b0, '0},
		'{ANG_TOP, VMAX, ONE, 32'sd0, 1'b0, '0},
		'{ANG_BOTTOM, VMIN, -ONE, 32'sd0, 1'b0, '0},
		'{26'sd1, VMAX, VMAX, 32'sd0, 1'b0, '0},
		'{-26'sd1, VMIN, VMAX, 32'sd0, 1'b0, '0},
		'{-26'sd1, 32'sd0, 32'sd0, -32'sd7, 1'b1, {32'sd0, 32'sd0, -32'sd7, 1'b0}},
		'{26'sd23592959, ONE, ONE, -ONE, 1'b0, '0}
	};

	rot_t rot_expected [$];
	logic signed [ANG_W-1:0] angle_now;
	longint cos_q30;
	longint sin_q30;
	bit quiet;
	int error_count;

	z_axis_vector_rotation #(
		.CORDIC_STAGES(STAGES),
		.FRACTION_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic flag_error(input string what);
		$display("ERROR at %0t: %s", $time, what);
		error_count++;
	endtask

	// Cosine and sine in Q2.30 of an angle in Q10.16 degrees.
	function automatic void derive_trig(input logic signed [ANG_W-1:0] ang,
			output longint c, output longint s);
		longint turn_units;
		longint red;
		longint bam_wide;
		longint res;
		longint xc;
		longint yc;
		longint dx;
		longint dy;
		logic [31:0] bam;
		logic [31:0] resid;
		logic [1:0] quad;
		int i;
		turn_units = longint'(360) << FRAC;
		red = longint'(ang) % turn_units;
		if (red < 0) begin
			red += turn_units;
		end
		// Dividing after adding half of 360 rounds the binary angle half up.
		bam_wide = ((red << (32 - FRAC)) + 64'sd180) / 64'sd360;
		bam = bam_wide[31:0];
		quad = 2'((bam + 32'h2000_0000) >> 30);
		resid = bam - {quad, 30'b0};
		res = longint'($signed(resid));
		xc = longint'(KINV_Q30);
		yc = 0;
		for (i = 0; i < STAGES; i++) begin
			dx = yc >>> i;
			dy = xc >>> i;
			if (res >= 0) begin
				xc -= dx;
				yc += dy;
				res -= arctan_step[i];
			end else begin
				xc += dx;
				yc -= dy;
				res += arctan_step[i];
			end
		end
		case (quad)
			2'd1: begin
				c = -yc;
				s = xc;
			end
			2'd2: begin
				c = -xc;
				s = -yc;
			end
			2'd3: begin
				c = yc;
				s = -xc;
			end
			default: begin
				c = xc;
				s = yc;
			end
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] clip_word(input longint v, inout logic flag);
		if (v > 64'sd2147483647) begin
			flag = 1'b1;
			return SAT_MAX;
		end
		if (v < -64'sd2147483648) begin
			flag = 1'b1;
			return SAT_MIN;
		end
		return v[31:0];
	endfunction

	function automatic rot_t rotate_vec(input vec_t v);
		longint px;
		longint py;
		rot_t r;
		px = (longint'(v.vec_x) * cos_q30 - longint'(v.vec_y) * sin_q30 + HALF_LSB) >>> 30;
		py = (longint'(v.vec_x) * sin_q30 + longint'(v.vec_y) * cos_q30 + HALF_LSB) >>> 30;
		r.saturated = 1'b0;
		r.rot_x = clip_word(px, r.saturated);
		r.rot_y = clip_word(py, r.saturated);
		r.rot_z = v.vec_z;
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_word(input int unsigned mode);
		if (mode < 4) begin
			return DATA_W'($urandom);
		end
		if (mode < 8) begin
			// Magnitudes that stay well clear of saturation.
			return $signed(DATA_W'($urandom)) >>> 11;
		end
		case ($urandom_range(0, 6))
			0: return VMIN;
			1: return VMAX;
			2: return 32'sd0;
			3: return -32'sd1;
			4: return ONE;
			5: return -ONE;
			default: return 32'sd1;
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat.
	task automatic send_vec(input vec_t v, input bit known, input rot_t want);
		int gap;
		gap = quiet ? 0 : int'($urandom_range(0, 4));
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data = v;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		rot_expected.push_back(known ? want : rotate_vec(v));
		@(negedge clk);
	endtask

	// The angle may only change with the pipeline empty and setup finished.
	task automatic load_angle(input logic signed [ANG_W-1:0] a);
		in_valid = 1'b0;
		while (rot_expected.size() != 0) @(negedge clk);
		repeat (PIPE_DEPTH) @(negedge clk);
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		cfg_wdata = a;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		angle_now = a;
		derive_trig(a, cos_q30, sin_q30);
	endtask

	initial begin
		int n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			n = quiet ? 0 : int'($urandom_range(0, 4));
			if (n > 0) begin
				out_ready = 1'b0;
				repeat (n) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		rot_t want;
		if (arst_n && out_valid && out_ready) begin
			if (rot_expected.size() == 0) begin
				flag_error($sformatf("result beat with no vector pending: %h", out_data));
			end else begin
				want = rot_expected.pop_front();
				if (out_data.rot_x !== want.rot_x) begin
					flag_error($sformatf("rot_x %h, expected %h", out_data.rot_x, want.rot_x));
				end
				if (out_data.rot_y !== want.rot_y) begin
					flag_error($sformatf("rot_y %h, expected %h", out_data.rot_y, want.rot_y));
				end
				if (out_data.rot_z !== want.rot_z) begin
					flag_error($sformatf("rot_z %h, expected %h", out_data.rot_z, want.rot_z));
				end
				if (out_data.saturated !== want.saturated) begin
					flag_error($sformatf("saturated %b, expected %b",
						out_data.saturated, want.saturated));
				end
			end
		end
	end

	initial begin
		int row;
		int ph;
		int k;
		int unsigned mode;
		logic signed [ANG_W-1:0] ang;
		vec_t v;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		quiet = 1'b0;
		error_count = 0;
		angle_now = ANGLE_RESET;
		derive_trig(angle_now, cos_q30, sin_q30);
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The first rows run on the angle left by reset.
		for (row = 0; row < 25; row++) begin
			if (probes[row].angle !== angle_now) begin
				load_angle(probes[row].angle);
			end
			v.vec_x = probes[row].x;
			v.vec_y = probes[row].y;
			v.vec_z = probes[row].z;
			send_vec(v, probes[row].known, probes[row].want);
		end

		for (ph = 0; ph < PHASES; ph++) begin
			case ($urandom_range(0, 4))
				0: ang = ANG_W'(int'($urandom_range(0, 47185920)) - 23592960);
				1: ang = ANG_W'($urandom);
				2: ang = ANG_W'((int'($urandom_range(0, 8)) - 4) * 5898240);
				3: ang = ANG_W'((int'($urandom_range(0, 15)) - 8) * 2949120
					+ int'($urandom_range(0, 2)) - 1);
				default: ang = ANG_W'(int'($urandom_range(0, 2000)) - 1000);
			endcase
			if (ang !== angle_now) begin
				load_angle(ang);
			end
			quiet = (ph % 4 == 3);
			for (k = 0; k < BEATS_PER_PHASE; k++) begin
				mode = $urandom_range(0, 9);
				v.vec_x = pick_word(mode);
				v.vec_y = pick_word(mode);
				v.vec_z = DATA_W'($urandom);
				send_vec(v, 1'b0, '0);
			end
		end

		in_valid = 1'b0;
		while (rot_expected.size() != 0) @(posedge clk);
		repeat (2 * PIPE_DEPTH) @(posedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
